### rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/eqz_pkg.sv
`timescale 1ns / 1ps

package eqz_pkg;

    // filter and sample setup
    localparam int SAMPLE_WIDTH   = 16;
    localparam int LP1_CUTOFF_HZ  = 150;
    localparam int LP2_CUTOFF_HZ  = 600;
    localparam int LP3_CUTOFF_HZ  = 2000;
    localparam int LP4_CUTOFF_HZ  = 7000;
    localparam int SAMPLE_RATE_HZ = 44100;

    // datapath widths
    localparam int BAND_W  = SAMPLE_WIDTH + 2;
    localparam int COEF_W  = 24;
    localparam int STATE_W = 40;
    localparam int PROD_W  = COEF_W + BAND_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int GAIN_W  = 12;

    localparam int NUM_STAGES = 4;
    localparam int NUM_GAINS  = 5;
    localparam int STAGE_IW   = 2;
    localparam int BAND_IW    = 3;
    localparam int CFG_IW     = 3;

    // gain register indexes
    localparam logic [CFG_IW-1:0] REG_GAIN_SUB      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_GAIN_LOW_MID  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_GAIN_HIGH_MID = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GAIN_UPPER    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_GAIN_TOP      = 3'd4;

    typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] t_gains;

    localparam t_gains GAIN_RESET = {12'd461, 12'd563, 12'd486, 12'd128, 12'd77};

    // biquad coefficients, Q2.22, b2 equals b0
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coef;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BQ_MUL,
        OP_BQ_ACC,
        OP_BQ_ROUND,
        OP_BQ_FB1,
        OP_BQ_FB2,
        OP_BQ_FB3,
        OP_GAIN,
        OP_GAIN_SUM,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [STAGE_IW-1:0] stage;
        logic [BAND_IW-1:0]  band;
        logic                first;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BQ_MUL,
        ST_BQ_ACC,
        ST_BQ_ROUND,
        ST_BQ_FB1,
        ST_BQ_FB2,
        ST_BQ_FB3,
        ST_GAIN,
        ST_GAIN_SUM,
        ST_OUT
    } t_state;

    // elaboration-time math, Q30 fixed point
    localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam logic [63:0] INV_SQRT2_Q30 = 64'd759250125;
    localparam longint      COEF_MAX      = (longint'(1) <<< 23) - 1;
    localparam longint      COEF_MIN      = -(longint'(1) <<< 23);

    // restoring divide, used only for constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // num/den rounded to Q22, sign kept, saturated to the coefficient range
    function automatic logic signed [COEF_W-1:0] div_q22(input longint num, input longint den);
        logic [63:0] mag;
        longint      r;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        r   = longint'(udiv64((mag << 23) + 64'(den), 64'(den) << 1));
        if (num < 0) begin
            r = -r;
        end
        if (r > COEF_MAX) begin
            r = COEF_MAX;
        end
        if (r < COEF_MIN) begin
            r = COEF_MIN;
        end
        return r[COEF_W-1:0];
    endfunction

    // butterworth low-pass design from taylor sin/cos of the half angle
    function automatic t_coef lp_design(input longint f_in);
        t_coef       c;
        longint      f;
        longint      fs;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] ts;
        logic [63:0] tc;
        longint      s;
        longint      co;
        longint      sinw;
        longint      cosw;
        longint      alpha;
        longint      a0;
        longint      omc;
        fs = (SAMPLE_RATE_HZ < 1) ? longint'(1) : longint'(SAMPLE_RATE_HZ);
        f  = (f_in < 0) ? longint'(0) : f_in;
        if (f > (fs >>> 1)) begin
            f = fs >>> 1;
        end
        h  = udiv64(PI_Q30 * 64'(f), 64'(fs));
        h2 = (h * h) >> 30;
        ts = h;
        tc = Q30_ONE;
        s  = longint'(h);
        co = longint'(Q30_ONE);
        for (int k = 1; k <= 10; k++) begin
            ts = udiv64((ts * h2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = udiv64((tc * h2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1) begin
                s  = s - longint'(ts);
                co = co - longint'(tc);
            end else begin
                s  = s + longint'(ts);
                co = co + longint'(tc);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (co < 0) begin
            co = 0;
        end
        sinw  = longint'((64'(s) * 64'(co) * 64'd2) >> 30);
        cosw  = longint'(Q30_ONE) - longint'((64'(s) * 64'(s) * 64'd2) >> 30);
        alpha = longint'((64'(sinw) * INV_SQRT2_Q30) >> 30);
        a0    = longint'(Q30_ONE) + alpha;
        omc   = longint'(Q30_ONE) - cosw;
        c.b0  = div_q22(omc >>> 1, a0);
        c.b1  = div_q22(omc, a0);
        c.a1  = div_q22(-2 * cosw, a0);
        c.a2  = div_q22(longint'(Q30_ONE) - alpha, a0);
        return c;
    endfunction

    localparam t_coef LP_COEF [NUM_STAGES] = '{
        lp_design(longint'(LP1_CUTOFF_HZ)),
        lp_design(longint'(LP2_CUTOFF_HZ)),
        lp_design(longint'(LP3_CUTOFF_HZ)),
        lp_design(longint'(LP4_CUTOFF_HZ))
    };

endpackage

### rtl/five_band_audio_equalizer_top.sv
`timescale 1ns / 1ps

// five-band equalizer: four cascaded low-pass biquads split each sample into
// bands, which are weighted by the gain registers and summed with saturation.
// input channel: i_in_valid / o_in_ready with i_sample_in; a word is taken
// when both are high. output channel: o_out_valid / i_out_ready with
// o_sample_out and o_clipped.
// one shared 24x18 multiplier is sequenced by the controller: the biquad
// states of each stage, then the gain, gain-sum and output states. a new word
// is taken only once the sequencer is back in idle, not while one is still in
// flight; the multiplier and its accumulate loop set this pacing.
// o_in_ready is high whenever the sequencer is idle, also while a result
// waits in the output register; if the receiver stalls, the next result is
// held back until the waiting word is taken.
// gains are written via i_cfg_we / i_cfg_idx / i_cfg_data; write them only
// while idle, which the block does not enforce. indexes above four are ignored.
// reset (synchronous, active low) clears the filter state and the output
// valid, and loads the default gains.
module five_band_audio_equalizer_top
    import eqz_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_clipped,
    input  logic                           i_cfg_we,
    input  logic [CFG_IW-1:0]              i_cfg_idx,
    input  logic [GAIN_W-1:0]              i_cfg_data
);

    t_gains r_gains;
    t_cmd   cmd;

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= GAIN_RESET;
        end else if (i_cfg_we && i_cfg_idx <= REG_GAIN_TOP) begin
            r_gains[i_cfg_idx] <= i_cfg_data;
        end
    end

    eqz_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    eqz_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_gains   (r_gains),
        .i_sample  (i_sample_in),
        .o_sample  (o_sample_out),
        .o_clipped (o_clipped)
    );

endmodule

### rtl/eqz_ctrl.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module eqz_ctrl
    import eqz_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state              r_state;
    t_state              n_state;
    logic [STAGE_IW-1:0] r_stage;
    logic [BAND_IW-1:0]  r_band;
    logic                r_out_valid;
    logic                out_free;
    logic                last_stage;
    logic                last_band;

    assign out_free   = !r_out_valid || i_out_ready;
    assign last_stage = (r_stage == STAGE_IW'(NUM_STAGES - 1));
    assign last_band  = (r_band == BAND_IW'(NUM_GAINS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_BQ_MUL;
                end
            end
            ST_BQ_MUL:   n_state = ST_BQ_ACC;
            ST_BQ_ACC:   n_state = ST_BQ_ROUND;
            ST_BQ_ROUND: n_state = ST_BQ_FB1;
            ST_BQ_FB1:   n_state = ST_BQ_FB2;
            ST_BQ_FB2:   n_state = ST_BQ_FB3;
            ST_BQ_FB3:   n_state = last_stage ? ST_GAIN : ST_BQ_MUL;
            ST_GAIN:     n_state = last_band ? ST_GAIN_SUM : ST_GAIN;
            ST_GAIN_SUM: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.stage = r_stage;
        o_cmd.band  = r_band;
        o_cmd.first = (r_band == '0);
        case (r_state)
            ST_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            ST_BQ_MUL:   o_cmd.op = OP_BQ_MUL;
            ST_BQ_ACC:   o_cmd.op = OP_BQ_ACC;
            ST_BQ_ROUND: o_cmd.op = OP_BQ_ROUND;
            ST_BQ_FB1:   o_cmd.op = OP_BQ_FB1;
            ST_BQ_FB2:   o_cmd.op = OP_BQ_FB2;
            ST_BQ_FB3:   o_cmd.op = OP_BQ_FB3;
            ST_GAIN:     o_cmd.op = OP_GAIN;
            ST_GAIN_SUM: o_cmd.op = OP_GAIN_SUM;
            ST_OUT:      o_cmd.op = out_free ? OP_OUT : OP_NONE;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    // no word is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // state, stage and band counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stage <= '0;
            r_band  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_stage <= '0;
                r_band  <= '0;
            end else if (r_state == ST_BQ_FB3) begin
                r_stage <= r_stage + 1'b1;
            end else if (r_state == ST_GAIN) begin
                r_band <= r_band + 1'b1;
            end
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `ASSERT_NEXT(a_accept_starts_stage0, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_BQ_MUL && r_stage == '0, "accepted word did not start at the first stage")
    `ASSERT_NEXT(a_last_stage_to_gain, i_clk, i_rst_n, r_state == ST_BQ_FB3 && last_stage, r_state == ST_GAIN && r_band == '0, "gain phase not entered after the last stage")
    `ASSERT_NEXT(a_out_waits, i_clk, i_rst_n, r_state == ST_OUT && r_out_valid && !i_out_ready, r_state == ST_OUT && r_out_valid, "result overwrote a word still waiting")

endmodule

### rtl/eqz_dp.sv
`timescale 1ns / 1ps

module eqz_dp
    import eqz_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  t_gains                         i_gains,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic                           o_clipped
);

    localparam int YR_W  = ACC_W - 22;
    localparam int OUT_W = ACC_W - 8;

    // saturate an accumulator value to the state width
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-STATE_W:0] top;
        top = v[ACC_W-1:STATE_W-1];
        if (&top || ~|top) begin
            return v[STATE_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

    // saturate the shifted filter output to the band width
    function automatic logic signed [BAND_W-1:0] sat_band_y(input logic signed [YR_W-1:0] v);
        logic [YR_W-BAND_W:0] top;
        top = v[YR_W-1:BAND_W-1];
        if (&top || ~|top) begin
            return v[BAND_W-1:0];
        end else if (v[YR_W-1]) begin
            return {1'b1, {(BAND_W-1){1'b0}}};
        end else begin
            return {1'b0, {(BAND_W-1){1'b1}}};
        end
    endfunction

    // saturate the residual difference to the band width
    function automatic logic signed [BAND_W-1:0] sat_band_r(input logic signed [BAND_W:0] v);
        if (v[BAND_W] == v[BAND_W-1]) begin
            return v[BAND_W-1:0];
        end else if (v[BAND_W]) begin
            return {1'b1, {(BAND_W-1){1'b0}}};
        end else begin
            return {1'b0, {(BAND_W-1){1'b1}}};
        end
    endfunction

    logic signed [BAND_W-1:0]  r_x;
    logic signed [BAND_W-1:0]  r_y;
    logic signed [BAND_W-1:0]  r_bands [NUM_STAGES];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_bx;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [STATE_W-1:0] r_z1 [NUM_STAGES];
    logic signed [STATE_W-1:0] r_z2 [NUM_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic                      r_clip;

    t_coef                     coef;
    logic signed [COEF_W-1:0]  mul_a;
    logic signed [BAND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [BAND_W-1:0]  band_val;
    logic [GAIN_W-1:0]         gain_val;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [BAND_W-1:0]  y_new;
    logic signed [ACC_W-1:0]   z1_diff;
    logic signed [ACC_W-1:0]   z2_diff;
    logic signed [BAND_W:0]    res_diff;
    logic signed [ACC_W-1:0]   sum_rnd;
    logic signed [OUT_W-1:0]   out_full;
    logic [OUT_W-SAMPLE_WIDTH:0] out_top;

    assign coef     = LP_COEF[i_cmd.stage];
    assign band_val = (i_cmd.band == BAND_IW'(NUM_STAGES)) ? r_x : r_bands[i_cmd.band[STAGE_IW-1:0]];
    assign gain_val = i_gains[i_cmd.band];

    // shared multiplier operand select
    always_comb begin
        mul_a = coef.b0;
        mul_b = r_x;
        case (i_cmd.op)
            OP_BQ_MUL: begin
                mul_a = coef.b0;
                mul_b = r_x;
            end
            OP_BQ_ACC: begin
                mul_a = coef.b1;
                mul_b = r_x;
            end
            OP_BQ_FB1: begin
                mul_a = coef.a1;
                mul_b = r_y;
            end
            OP_BQ_FB2: begin
                mul_a = coef.a2;
                mul_b = r_y;
            end
            OP_GAIN: begin
                mul_a = $signed({{(COEF_W-GAIN_W){1'b0}}, gain_val});
                mul_b = band_val;
            end
            default: begin
                mul_a = coef.b0;
                mul_b = r_x;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // filter output rounding and feedback terms
    assign acc_rnd  = r_acc + (ACC_W'(1) <<< 21);
    assign y_new    = sat_band_y(acc_rnd[ACC_W-1:22]);
    assign z1_diff  = r_acc - ACC_W'(r_prod);
    assign z2_diff  = ACC_W'(r_bx) - ACC_W'(r_prod);
    assign res_diff = (BAND_W+1)'(r_x) - (BAND_W+1)'(r_y);

    // output rounding and clip detect
    assign sum_rnd  = r_acc + ACC_W'(128);
    assign out_full = sum_rnd[ACC_W-1:8];
    assign out_top  = out_full[OUT_W-1:SAMPLE_WIDTH-1];

    // product, accumulator, band and output registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x <= BAND_W'(i_sample);
            end
            OP_BQ_MUL: begin
                r_prod <= mul_p;
            end
            OP_BQ_ACC: begin
                r_acc  <= ACC_W'(r_prod) + ACC_W'(r_z1[i_cmd.stage]);
                r_bx   <= r_prod;
                r_prod <= mul_p;
            end
            OP_BQ_ROUND: begin
                r_y                  <= y_new;
                r_bands[i_cmd.stage] <= y_new;
                r_acc                <= ACC_W'(r_prod) + ACC_W'(r_z2[i_cmd.stage]);
            end
            OP_BQ_FB1: begin
                r_prod <= mul_p;
            end
            OP_BQ_FB2: begin
                r_prod <= mul_p;
                r_x    <= sat_band_r(res_diff);
            end
            OP_GAIN: begin
                r_prod <= mul_p;
                r_acc  <= i_cmd.first ? '0 : r_acc + ACC_W'(r_prod);
            end
            OP_GAIN_SUM: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_OUT: begin
                if (&out_top || ~|out_top) begin
                    r_out  <= out_full[SAMPLE_WIDTH-1:0];
                    r_clip <= 1'b0;
                end else begin
                    r_out  <= out_full[OUT_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                                : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                    r_clip <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // biquad delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_BQ_FB2: r_z1[i_cmd.stage] <= sat_state(z1_diff);
                OP_BQ_FB3: r_z2[i_cmd.stage] <= sat_state(z2_diff);
                default: begin
                end
            endcase
        end
    end

    assign o_sample  = r_out;
    assign o_clipped = r_clip;

endmodule
